// ----- rtl/core/tcsv_pkg.sv -----
// Package for the two-column CSV tokenizer: beat payload types, parser
// mode type, character constants and error codes. No dependencies.
`default_nettype none

package tcsv_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_COLUMN_COUNT = 3'd1;
  localparam logic [2:0] ERR_EMPTY_VIEW   = 3'd2;
  localparam logic [2:0] ERR_EMPTY_MSG    = 3'd3;
  localparam logic [2:0] ERR_AFTER_QUOTE  = 3'd4;
  localparam logic [2:0] ERR_STRAY_QUOTE  = 3'd5;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd6;

  typedef enum logic [1:0] {
    MODE_PLAIN      = 2'd0,
    MODE_QUOTED     = 2'd1,
    MODE_QUOTE_SEEN = 2'd2,
    MODE_CLOSED     = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] field_byte;
    logic [1:0] column;
    logic       field_end;
    logic       record_end;
    logic       error_flag;
    logic [2:0] error_code;
    logic       text_done;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/two_column_csv_tokenizer.sv -----
// Two-column CSV tokenizer: one text byte or end-of-text marker per input
// beat, one result beat per input beat. Depends on tcsv_pkg.
//
// Usage: the item channel (item_valid, item_stall, item) carries one CSV
// byte or an end-of-text marker per beat. The result channel (result_valid,
// result_stall, result) returns exactly one beat per item: a field byte
// with its column, field and record end marks, the first error, and the
// end-of-text acknowledge.
// The registered result appears in the cycle after acceptance. Throughput
// is one item per cycle while result_stall is low, set by the single
// parser state update between the item boundary and the result register.
// The result register frees itself in the same cycle it is taken, so
// item_stall is high only while a result is held and result_stall is high.
// Reset clears the parser state and empties the result register. An
// end-of-text beat flushes a pending record and returns the parser to its
// reset state. After an error, byte beats give empty results until end of
// text.
`default_nettype none

module two_column_csv_tokenizer
  import tcsv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  mode_t      mode, mode_next;
  logic       plain_char, plain_char_next;
  logic       field_not_empty, field_not_empty_next;
  logic [1:0] columns_seen, columns_seen_next;
  logic       view_not_empty, view_not_empty_next;
  logic       swallow_lf, swallow_lf_next;
  logic       failed, failed_next;
  result_t    res;
  logic       accept;

  logic       skip;
  logic       fin;
  logic       fin_rec;
  logic       emit;
  logic [7:0] emit_byte;
  logic       raise;
  logic [2:0] raise_code;
  logic       is_comma;
  logic       is_eol;
  logic [1:0] cur_column;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign is_comma   = (item.text_byte == CH_COMMA);
  assign is_eol     = (item.text_byte == CH_LF) || (item.text_byte == CH_CR);
  assign cur_column = (columns_seen >= 2'd2) ? 2'd2 : columns_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_PLAIN;
      plain_char      <= 1'b0;
      field_not_empty <= 1'b0;
      columns_seen    <= 2'd0;
      view_not_empty  <= 1'b0;
      swallow_lf      <= 1'b0;
      failed          <= 1'b0;
    end else if (accept) begin
      mode            <= mode_next;
      plain_char      <= plain_char_next;
      field_not_empty <= field_not_empty_next;
      columns_seen    <= columns_seen_next;
      view_not_empty  <= view_not_empty_next;
      swallow_lf      <= swallow_lf_next;
      failed          <= failed_next;
    end
  end

  always_comb begin
    mode_next            = mode;
    plain_char_next      = plain_char;
    field_not_empty_next = field_not_empty;
    columns_seen_next    = columns_seen;
    view_not_empty_next  = view_not_empty;
    swallow_lf_next      = swallow_lf;
    failed_next          = failed;
    res                  = '0;
    skip                 = 1'b0;
    fin                  = 1'b0;
    fin_rec              = 1'b0;
    emit                 = 1'b0;
    emit_byte            = item.text_byte;
    raise                = 1'b0;
    raise_code           = ERR_NONE;

    if (item.end_of_text) begin
      res.text_done = 1'b1;
      if (!failed) begin
        if (mode == MODE_QUOTED) begin
          raise      = 1'b1;
          raise_code = ERR_UNTERMINATED;
        end else if (mode != MODE_PLAIN || plain_char || columns_seen != 2'd0) begin
          fin     = 1'b1;
          fin_rec = 1'b1;
        end
      end
    end else if (!failed) begin
      if (swallow_lf) begin
        swallow_lf_next = 1'b0;
        skip            = (item.text_byte == CH_LF);
      end
      if (!skip) begin
        unique case (mode)
          MODE_QUOTED: begin
            if (item.text_byte == CH_QUOTE) begin
              mode_next = MODE_QUOTE_SEEN;
            end else begin
              emit = 1'b1;
            end
          end
          MODE_QUOTE_SEEN, MODE_CLOSED: begin
            if (mode == MODE_QUOTE_SEEN && item.text_byte == CH_QUOTE) begin
              emit      = 1'b1;
              emit_byte = CH_QUOTE;
              mode_next = MODE_QUOTED;
            end else if (is_comma || is_eol) begin
              fin     = 1'b1;
              fin_rec = is_eol;
            end else begin
              raise      = 1'b1;
              raise_code = ERR_AFTER_QUOTE;
            end
          end
          default: begin
            if (is_comma || is_eol) begin
              fin     = 1'b1;
              fin_rec = is_eol;
            end else if (item.text_byte == CH_QUOTE) begin
              if (plain_char) begin
                raise      = 1'b1;
                raise_code = ERR_STRAY_QUOTE;
              end else begin
                mode_next = MODE_QUOTED;
              end
            end else begin
              plain_char_next = 1'b1;
              emit            = 1'b1;
            end
          end
        endcase
        if (fin && item.text_byte == CH_CR) begin
          swallow_lf_next = 1'b1;
        end
      end
    end

    if (emit) begin
      res.byte_valid       = 1'b1;
      res.field_byte       = emit_byte;
      res.column           = cur_column;
      field_not_empty_next = 1'b1;
    end

    if (fin) begin
      res.field_end = 1'b1;
      res.column    = cur_column;
      if (fin_rec) begin
        if (columns_seen != 2'd1) begin
          raise      = 1'b1;
          raise_code = ERR_COLUMN_COUNT;
        end else if (!view_not_empty) begin
          raise      = 1'b1;
          raise_code = ERR_EMPTY_VIEW;
        end else if (!field_not_empty) begin
          raise      = 1'b1;
          raise_code = ERR_EMPTY_MSG;
        end else begin
          res.record_end = 1'b1;
        end
        columns_seen_next   = 2'd0;
        view_not_empty_next = 1'b0;
      end else begin
        if (columns_seen == 2'd0) begin
          view_not_empty_next = field_not_empty;
        end
        if (columns_seen != 2'd3) begin
          columns_seen_next = columns_seen + 2'd1;
        end
      end
      plain_char_next      = 1'b0;
      field_not_empty_next = 1'b0;
      mode_next            = MODE_PLAIN;
    end

    if (raise) begin
      if (!failed) begin
        res.error_flag = 1'b1;
        res.error_code = raise_code;
      end
      failed_next = 1'b1;
    end

    if (item.end_of_text) begin
      mode_next            = MODE_PLAIN;
      plain_char_next      = 1'b0;
      field_not_empty_next = 1'b0;
      columns_seen_next    = 2'd0;
      view_not_empty_next  = 1'b0;
      swallow_lf_next      = 1'b0;
      failed_next          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire
